// ===== rtl/acpp_pkg.sv =====
// ----------------------------------------------------------------------------
// acpp_pkg
// Shared types, constants and tables for the ASCII parameter command parser.
// ----------------------------------------------------------------------------
package acpp_pkg;

	// number formats
	localparam int PARAM_BITS = 16;
	localparam int FRAC_BITS  = 16;
	localparam int INT_BITS   = 32 - FRAC_BITS;
	localparam int SCALE_BITS = 24;
	localparam int RND_SHIFT  = SCALE_BITS - FRAC_BITS;
	localparam int TERM_BITS  = SCALE_BITS + 4;

	localparam logic [PARAM_BITS-1:0] PARAM_MAX = '1;
	localparam logic [INT_BITS-1:0]   INT_MAX   = '1;
	localparam logic [TERM_BITS-1:0]  RND_ADD   = (TERM_BITS'(1) << RND_SHIFT) >> 1;

	// token queue between the front and the back
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	// characters
	localparam logic [7:0] CH_P    = 8'h50;
	localparam logic [7:0] CH_EQ   = 8'h3D;
	localparam logic [7:0] CH_DOT  = 8'h2E;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	// result kinds
	localparam logic KIND_GET = 1'b0;
	localparam logic KIND_SET = 1'b1;

	typedef enum logic [2:0] {
		TOK_P,
		TOK_EQ,
		TOK_DOT,
		TOK_TERM,
		TOK_DIGIT
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [3:0]  digit;
	} token_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] number;
		logic [31:0] value;
	} result_t;

	// weight of the next fraction digit, Q0.24, starting at 0.1 and divided by ten
	localparam int SIDX_LAST = 7;

	function automatic logic [SCALE_BITS-1:0] frac_scale(input logic [2:0] idx);
		logic [SCALE_BITS-1:0] s;
		case (idx)
			3'd0:    s = 24'd1677722;
			3'd1:    s = 24'd167772;
			3'd2:    s = 24'd16777;
			3'd3:    s = 24'd1677;
			3'd4:    s = 24'd167;
			3'd5:    s = 24'd16;
			3'd6:    s = 24'd1;
			default: s = 24'd0;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/ascii_param_command_parser_top.sv =====
// ----------------------------------------------------------------------------
// ascii_param_command_parser_top
// Parses "P NNN<term>" get and "P NNN=III.FFF<term>" set requests from UART bytes.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while full is low; one token a cycle while the request queue has room.
// A terminator waits in the token queue; when the back end takes it, its request is queued (empty low).
// full rises only when the four-entry token queue is full, i.e. while the two-entry
// request queue stays full because pop is held low.
// Reset: arst_n low clears both queues and returns the parser to waiting for P.
// ----------------------------------------------------------------------------
module ascii_param_command_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	// byte side
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	// request side
	output logic        empty,
	input  logic        pop,
	output logic        cmd_kind,
	output logic [15:0] param_number,
	output logic [31:0] param_value
);
	import acpp_pkg::*;

	// tokens between the classifier and the parser
	logic   tok_valid;
	logic   tok_pop;
	token_t tok;

	// Front end: classify each byte as P, '=', '.', terminator or digit, drop
	// anything else, and hold the tokens in a short queue.
	acpp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.rx_byte   (rx_byte),
		.tok_pop   (tok_pop),
		.tok_valid (tok_valid),
		.tok       (tok)
	);

	// Back end: advance the phase machine, accumulate the parameter number and
	// the Q16.16 value with saturation, and queue each finished request.
	acpp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.tok_valid    (tok_valid),
		.tok          (tok),
		.tok_pop      (tok_pop),
		.empty        (empty),
		.pop          (pop),
		.cmd_kind     (cmd_kind),
		.param_number (param_number),
		.param_value  (param_value)
	);

endmodule

// ===== rtl/acpp_front.sv =====
// ----------------------------------------------------------------------------
// acpp_front
// Classifies received bytes into tokens and queues them for the back end.
// ----------------------------------------------------------------------------
module acpp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [7:0]      rx_byte,
	input  logic            tok_pop,
	output logic            tok_valid,
	output acpp_pkg::token_t tok
);
	import acpp_pkg::*;

	token_t             tok_mem [QDEPTH];
	logic [QPTR_W-1:0]  wptr_q;
	logic [QPTR_W-1:0]  rptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	token_t             cls;
	logic               keep;
	logic               wr;
	logic               rd;

	// classify; bytes that never matter are dropped here
	always_comb begin
		keep       = 1'b1;
		cls.kind   = TOK_DIGIT;
		cls.digit  = rx_byte[3:0];
		if (rx_byte inside {[CH_ZERO:CH_NINE]}) begin
			cls.kind = TOK_DIGIT;
		end else if (rx_byte == CH_P) begin
			cls.kind = TOK_P;
		end else if (rx_byte == CH_EQ) begin
			cls.kind = TOK_EQ;
		end else if (rx_byte == CH_DOT) begin
			cls.kind = TOK_DOT;
		end else if (rx_byte inside {CH_LF, CH_CR}) begin
			cls.kind = TOK_TERM;
		end else begin
			keep = 1'b0;
		end
	end

	assign full      = (cnt_q == QCNT_W'(QDEPTH));
	assign tok_valid = (cnt_q != '0);
	assign wr        = push && !full && keep;
	assign rd        = tok_pop && tok_valid;
	assign tok       = tok_mem[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			tok_mem[wptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/acpp_back.sv =====
// ----------------------------------------------------------------------------
// acpp_back
// Runs the command parser on queued tokens and buffers the finished requests.
// ----------------------------------------------------------------------------
module acpp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tok_valid,
	input  acpp_pkg::token_t tok,
	output logic             tok_pop,
	output logic             empty,
	input  logic             pop,
	output logic             cmd_kind,
	output logic [15:0]      param_number,
	output logic [31:0]      param_value
);
	import acpp_pkg::*;

	localparam logic [1:0] PH_WAIT  = 2'd0;
	localparam logic [1:0] PH_PARAM = 2'd1;
	localparam logic [1:0] PH_INT   = 2'd2;
	localparam logic [1:0] PH_FRAC  = 2'd3;

	logic [1:0]              phase_q;
	logic [PARAM_BITS-1:0]   param_q;
	logic [31:0]             value_q;
	logic [2:0]              sidx_q;

	logic [1:0]              phase_d;
	logic [PARAM_BITS-1:0]   param_d;
	logic [31:0]             value_d;
	logic [2:0]              sidx_d;

	logic [PARAM_BITS+3:0]   p_sum;
	logic [INT_BITS-1:0]     whole_val;
	logic [INT_BITS+3:0]     i_sum;
	logic [TERM_BITS-1:0]    t_prod;
	logic [TERM_BITS-1:0]    t_rnd;
	logic [32:0]             v_sum;

	logic                    take;
	logic                    res_valid;
	result_t                 res;

	result_t                 out_mem [2];
	logic                    owptr_q;
	logic                    orptr_q;
	logic [1:0]              ocnt_q;
	logic                    ord;

	assign take    = tok_valid && (ocnt_q != 2'd2);
	assign tok_pop = take;

	// digit arithmetic
	always_comb begin
		p_sum     = (PARAM_BITS+4)'({param_q, 3'b000}) + (PARAM_BITS+4)'({param_q, 1'b0})
			+ (PARAM_BITS+4)'(tok.digit);
		whole_val = value_q[31:FRAC_BITS];
		i_sum     = (INT_BITS+4)'({whole_val, 3'b000}) + (INT_BITS+4)'({whole_val, 1'b0})
			+ (INT_BITS+4)'(tok.digit);
		t_prod    = TERM_BITS'(frac_scale(sidx_q)) * TERM_BITS'(tok.digit);
		t_rnd     = (t_prod + RND_ADD) >> RND_SHIFT;
		v_sum     = {1'b0, value_q} + 33'(t_rnd);
	end

	// parser step
	always_comb begin
		phase_d   = phase_q;
		param_d   = param_q;
		value_d   = value_q;
		sidx_d    = sidx_q;
		res_valid = 1'b0;
		res.kind   = KIND_SET;
		res.number = 16'(param_q);
		res.value  = value_q;
		case (phase_q)
			PH_WAIT: begin
				if (tok.kind == TOK_P) begin
					phase_d = PH_PARAM;
				end
			end
			PH_PARAM: begin
				if (tok.kind == TOK_EQ) begin
					phase_d = PH_INT;
				end else if (tok.kind == TOK_TERM) begin
					res_valid = 1'b1;
					res.kind  = KIND_GET;
					res.value = '0;
				end else if (tok.kind == TOK_DIGIT) begin
					param_d = (p_sum > (PARAM_BITS+4)'(PARAM_MAX)) ? PARAM_MAX
						: p_sum[PARAM_BITS-1:0];
				end
			end
			PH_INT: begin
				if (tok.kind == TOK_TERM) begin
					res_valid = 1'b1;
				end else if (tok.kind == TOK_DOT) begin
					phase_d = PH_FRAC;
				end else if (tok.kind == TOK_DIGIT) begin
					value_d = {((i_sum > (INT_BITS+4)'(INT_MAX)) ? INT_MAX
						: i_sum[INT_BITS-1:0]), FRAC_BITS'(0)};
				end
			end
			default: begin
				if (tok.kind == TOK_TERM) begin
					res_valid = 1'b1;
				end else if (tok.kind == TOK_DIGIT) begin
					value_d = v_sum[32] ? 32'hFFFF_FFFF : v_sum[31:0];
					if (sidx_q != 3'(SIDX_LAST)) begin
						sidx_d = sidx_q + 1'b1;
					end
				end
			end
		endcase
		// a request clears the parser
		if (res_valid) begin
			phase_d = PH_WAIT;
			param_d = '0;
			value_d = '0;
			sidx_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			param_q <= '0;
			value_q <= '0;
			sidx_q  <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			param_q <= param_d;
			value_q <= value_d;
			sidx_q  <= sidx_d;
		end
	end

	// two-entry request queue towards the consumer
	assign empty        = (ocnt_q == 2'd0);
	assign ord          = pop && !empty;
	assign cmd_kind     = out_mem[orptr_q].kind;
	assign param_number = out_mem[orptr_q].number;
	assign param_value  = out_mem[orptr_q].value;

	always_ff @(posedge clk) begin
		if (take && res_valid) begin
			out_mem[owptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owptr_q <= 1'b0;
			orptr_q <= 1'b0;
			ocnt_q  <= 2'd0;
		end else begin
			if (take && res_valid) begin
				owptr_q <= ~owptr_q;
			end
			if (ord) begin
				orptr_q <= ~orptr_q;
			end
			if ((take && res_valid) && !ord) begin
				ocnt_q <= ocnt_q + 1'b1;
			end else if (ord && !(take && res_valid)) begin
				ocnt_q <= ocnt_q - 1'b1;
			end
		end
	end

	a_ocnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q != 2'd3)
		else $error("request queue count out of range");

	a_no_take_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(ocnt_q == 2'd2) |-> !tok_pop)
		else $error("token taken with request queue full");

	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && tok.kind == TOK_TERM && phase_q != PH_WAIT)
		|=> (phase_q == PH_WAIT && param_q == '0 && value_q == '0 && sidx_q == '0))
		else $error("terminator did not clear the parser");

	a_req_written: assert property (@(posedge clk) disable iff (!arst_n)
		(take && tok.kind == TOK_TERM && phase_q != PH_WAIT && !ord) |=> !empty)
		else $error("request lost after terminator");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ASCII parameter command parser. A short directed
// table covers the edge cases of the command syntax. Random command strings
// follow, most of them well formed, mixed with noise bytes. Every get and set
// request that leaves the block is checked against a predictor kept in step
// with the byte stream.
// ----------------------------------------------------------------------------
module testbench;
	import acpp_pkg::*;

	// widths and limits as the parser sees them
	localparam int NUM_BITS     = 16;
	localparam int FRAC_W       = 16;
	localparam int WHOLE_W      = 32 - FRAC_W;
	localparam int WEIGHT_SHIFT = 24 - FRAC_W;
	localparam int ROUND_HALF   = 1 << (WEIGHT_SHIFT - 1);
	localparam int WEIGHT_START = 1677722;    // 0.1 in Q0.24
	localparam logic [NUM_BITS-1:0] NUM_MAX   = '1;
	localparam logic [WHOLE_W-1:0]  WHOLE_MAX = '1;

	localparam int N_DIRECTED   = 27;
	localparam int RANDOM_BYTES = 1800;
	localparam int IDLE_PCT     = 18;
	localparam int SETTLE_WAIT  = 20;
	localparam int DRAIN_LIMIT  = 5000;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int MAX_REPORTS  = 10;

	typedef enum logic [1:0] {
		WAIT_P,
		PARAM_DIGITS,
		INT_DIGITS,
		FRAC_DIGITS
	} parse_phase_t;

	// one byte of stimulus; where typed is set, req is the request it must close
	typedef struct packed {
		logic [7:0] ch;
		logic       typed;
		result_t    req;
	} stim_row_t;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        push    = 1'b0;
	logic [7:0]  rx_byte = 8'h00;
	logic        pop     = 1'b0;
	logic        full;
	logic        empty;
	logic        cmd_kind;
	logic [15:0] param_number;
	logic [31:0] param_value;

	// no idling on either side while calm is high
	logic calm = 1'b0;

	// predictor state
	parse_phase_t         parse_ph;
	logic [NUM_BITS-1:0]  num_acc;
	logic [31:0]          val_acc;
	logic [23:0]          digit_weight;

	result_t   expected_requests[$];
	stim_row_t directed_rows[N_DIRECTED];

	int n_bytes     = 0;
	int n_get       = 0;
	int n_set       = 0;
	int n_errors    = 0;
	int cycle_count = 0;

	ascii_param_command_parser_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.rx_byte      (rx_byte),
		.empty        (empty),
		.pop          (pop),
		.cmd_kind     (cmd_kind),
		.param_number (param_number),
		.param_value  (param_value)
	);

	always #1 clk = ~clk;

	// Watchdog: end the run with an error once the count reaches CYCLE_LIMIT.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d requests outstanding",
				cycle_count, expected_requests.size());
			$display("testbench: errors");
			$finish;
		end
	end

	// Count every failure; print only the first few in full.
	task automatic flag_error(input string msg);
		n_errors++;
		if (n_errors <= MAX_REPORTS)
			$display("ERROR: %s", msg);
	endtask

	function automatic stim_row_t row(input logic [7:0] ch);
		return '{ch, 1'b0, '0};
	endfunction

	function automatic stim_row_t row_req(input logic [7:0] ch, input logic kind,
			input logic [15:0] number, input logic [31:0] value);
		return '{ch, 1'b1, '{kind, number, value}};
	endfunction

	task automatic clear_parse();
		parse_ph     = WAIT_P;
		num_acc      = '0;
		val_acc      = '0;
		digit_weight = 24'(WEIGHT_START);
	endtask

	// Advance the command parse by one byte; raise emitted when a request closes.
	task automatic parse_char(input logic [7:0] ch, output logic emitted, output result_t req);
		logic        is_term;
		logic        is_digit;
		logic [3:0]  dg;
		logic [31:0] num_next;
		logic [31:0] whole_next;
		logic [31:0] frac_term;
		logic [32:0] val_sum;
		emitted  = 1'b0;
		req      = '0;
		is_term  = (ch == CH_LF) || (ch == CH_CR);
		is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
		dg       = 4'(ch - CH_ZERO);
		case (parse_ph)
			WAIT_P: begin
				// everything but P is dropped here, terminators included
				if (ch == CH_P)
					parse_ph = PARAM_DIGITS;
			end
			PARAM_DIGITS: begin
				if (ch == CH_EQ) begin
					parse_ph = INT_DIGITS;
				end else if (is_term) begin
					emitted = 1'b1;
					req     = '{KIND_GET, num_acc[15:0], 32'd0};
				end else if (is_digit) begin
					num_next = num_acc * 10 + dg;
					num_acc  = (num_next > NUM_MAX) ? NUM_MAX : num_next[NUM_BITS-1:0];
				end
			end
			INT_DIGITS: begin
				if (is_term) begin
					emitted = 1'b1;
				end else if (ch == CH_DOT) begin
					parse_ph = FRAC_DIGITS;
				end else if (is_digit) begin
					whole_next = val_acc[31:FRAC_W] * 10 + dg;
					if (whole_next > WHOLE_MAX)
						whole_next = WHOLE_MAX;
					val_acc = {whole_next[WHOLE_W-1:0], {FRAC_W{1'b0}}};
				end
			end
			default: begin
				// fraction digits
				if (is_term) begin
					emitted = 1'b1;
				end else if (is_digit) begin
					// weight the digit in Q0.24, round half up to the value's grid
					frac_term    = digit_weight * dg;
					frac_term    = (frac_term + ROUND_HALF) >> WEIGHT_SHIFT;
					val_sum      = {1'b0, val_acc} + frac_term;
					val_acc      = val_sum[32] ? 32'hFFFF_FFFF : val_sum[31:0];
					digit_weight = 24'(digit_weight / 10);
				end
			end
		endcase
		if (emitted) begin
			if (parse_ph != PARAM_DIGITS)
				req = '{KIND_SET, num_acc[15:0], val_acc};
			clear_parse();
		end
	endtask

	// Offer one byte request, with random idle cycles ahead of it, and wait
	// for the block to take it. The prediction is made at the accepting edge.
	task automatic send_byte(input stim_row_t r);
		logic    emitted;
		result_t req;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push    <= 1'b1;
		rx_byte <= r.ch;
		@(posedge clk);
		while (full)
			@(posedge clk);
		parse_char(r.ch, emitted, req);
		// a typed row carries its own expectation and overrides the predictor
		if (r.typed)
			expected_requests.push_back(r.req);
		else if (emitted)
			expected_requests.push_back(req);
		n_bytes++;
		calm <= (n_bytes >= 700) && (n_bytes < 1000);
	endtask

	function automatic logic [7:0] rand_digit(input bit nines);
		return nines ? CH_NINE : CH_ZERO + 8'($urandom_range(9));
	endfunction

	// mostly short numbers, now and then long enough to saturate
	function automatic int digit_count();
		return ($urandom_range(3) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
	endfunction

	// One command with random content: P, parameter digits, optionally a value
	// with integer and fraction parts, then a terminator. Stray bytes and a
	// missing terminator now and then break the sequence.
	task automatic emit_command();
		bit nines;
		int n;
		nines = ($urandom_range(7) == 0);
		send_byte(row(CH_P));
		if ($urandom_range(9) == 0)
			send_byte(row(8'($urandom_range(255))));
		n = digit_count();
		repeat (n) send_byte(row(rand_digit(nines)));
		if ($urandom_range(3) != 0) begin
			send_byte(row(CH_EQ));
			n = digit_count();
			repeat (n) send_byte(row(rand_digit(nines)));
			if ($urandom_range(9) == 0)
				send_byte(row(8'($urandom_range(255))));
			if ($urandom_range(3) != 0) begin
				send_byte(row(CH_DOT));
				n = ($urandom_range(3) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 5);
				repeat (n) send_byte(row(rand_digit(nines)));
			end
		end
		if ($urandom_range(14) != 0)
			send_byte(row($urandom_range(1) ? CH_CR : CH_LF));
	endtask

	// Request side: check each popped request against the oldest expectation,
	// then decide whether to stall on the next cycle.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_requests.size() == 0) begin
					flag_error($sformatf("unexpected request kind=%0d number=%0d value=%h",
						cmd_kind, param_number, param_value));
				end else begin
					want = expected_requests.pop_front();
					if (cmd_kind !== want.kind || param_number !== want.number ||
							param_value !== want.value)
						flag_error($sformatf(
							"request mismatch: expected kind=%0d number=%0d value=%h, got kind=%0d number=%0d value=%h",
							want.kind, want.number, want.value,
							cmd_kind, param_number, param_value));
					if (want.kind == KIND_SET)
						n_set++;
					else
						n_get++;
				end
			end
			pop <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin
		int guard;

		// Directed table: syntax corners first. Rows with a typed request are
		// plain enough to read straight off the command text.
		directed_rows = '{
			row(CH_CR),                                   // terminator before any P
			row(CH_P),
			row_req(CH_LF, KIND_GET, 16'd0, 32'd0),       // bare P is a get of 0
			row(CH_P),
			row(CH_NINE), row(CH_NINE), row(CH_NINE), row(CH_NINE), row(CH_NINE),
			row_req(CH_CR, KIND_GET, 16'hFFFF, 32'd0),    // number saturates
			row(CH_P),
			row(CH_EQ),
			row_req(CH_LF, KIND_SET, 16'd0, 32'd0),       // empty value
			row(CH_P),
			row(CH_DOT),                                  // dot before '=' is dropped
			row("7"),
			row(CH_EQ),
			row(CH_P),                                    // second P is dropped
			row("3"),
			row(CH_DOT),
			row("5"),
			row(CH_EQ),                                   // late '=' is dropped
			row(CH_DOT),                                  // second dot is dropped
			row(CH_CR),
			row(CH_LF),                                   // terminator while idle again
			row(CH_EQ),
			row(8'hFF)
		};

		clear_parse();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_byte(directed_rows[i]);

		// Random part: mostly whole commands, the rest loose noise.
		while (n_bytes < N_DIRECTED + RANDOM_BYTES) begin
			if ($urandom_range(99) < 12)
				send_byte(row(8'($urandom_range(255))));
			else
				emit_command();
		end
		push <= 1'b0;

		// Drain: wait for every expected request, then hold a little longer so
		// that a stray extra request would still be caught.
		guard = 0;
		while (expected_requests.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_WAIT) @(posedge clk);
		if (expected_requests.size() != 0)
			flag_error($sformatf("%0d expected requests never arrived",
				expected_requests.size()));

		$display("summary: %0d bytes sent (%0d from the directed table) in %0d cycles",
			n_bytes, N_DIRECTED, cycle_count);
		$display("summary: %0d get and %0d set requests compared, %0d failures",
			n_get, n_set, n_errors);
		if (n_errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
